@@ design/dap_pkg.sv @@
// Shared types, constants and the arctangent table for the antenna pattern unit.
package dap_pkg;

   localparam int CW = 34;            // CORDIC datapath width (Q.30 plus headroom)
   localparam int ZW = 34;            // residual angle width, turns * 2^32
   localparam int VW = 28;            // Q.24 values, signed
   localparam int DW = 28;            // response matrix entries, Q.24, |D| < 2^26 for any arms
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

   localparam logic [2:0] REG_ARM_X_0 = 3'd0;
   localparam logic [2:0] REG_ARM_X_1 = 3'd1;
   localparam logic [2:0] REG_ARM_X_2 = 3'd2;
   localparam logic [2:0] REG_ARM_Y_0 = 3'd3;
   localparam logic [2:0] REG_ARM_Y_1 = 3'd4;
   localparam logic [2:0] REG_ARM_Y_2 = 3'd5;

   typedef logic signed [15:0] arm_type [3];
   typedef logic signed [VW-1:0] vec_type [3];

   function automatic logic [31:0] atan_turns(input int i);
      logic [31:0] t;
      case (i)
         0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
         3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
         6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
         9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
        12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
        15: t = 32'h0000517C; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
        18: t = 32'h00000A2F; 19: t = 32'h00000517; 20: t = 32'h0000028B;
        21: t = 32'h00000145; 22: t = 32'h000000A2; 23: t = 32'h00000051;
         default: t = 32'h0;
      endcase
      return t;
   endfunction

   // round to nearest (add half, floor) of a Q.48 product back to Q.24
   function automatic logic signed [VW-1:0] rq24(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = (p + 64'sd8388608) >>> 24;
      return t[VW-1:0];
   endfunction

endpackage

@@ design/dap_cordic.sv @@
// Pipelined CORDIC sine/cosine: one rotation per stage, quadrant fold at the end.
module dap_cordic #(
   parameter int ANGLE_BITS    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ANGLE_BITS-1:0]         angle,
   output logic signed [dap_pkg::VW-1:0] cos_out,
   output logic signed [dap_pkg::VW-1:0] sin_out
);
   import dap_pkg::*;

   localparam int N = (CORDIC_STAGES < 1) ? 1 : ((CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES);
   localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

   logic signed [CW-1:0] x_ff [N+1];
   logic signed [CW-1:0] y_ff [N+1];
   logic signed [ZW-1:0] z_ff [N+1];
   logic [1:0]           q_ff [N+1];

   logic [ANGLE_BITS-1:0] q_sum;
   logic [1:0]            q_in;
   logic [ANGLE_BITS-1:0] r_in;

   assign q_sum = angle + QUARTER;
   assign q_in  = q_sum[ANGLE_BITS-1 -: 2];
   // residual after removing the quarter turn just above the angle, signed, in [-1/4, 0)
   assign r_in  = angle - {q_in, {(ANGLE_BITS-2){1'b0}}};

   always_ff @(posedge clock) begin
      x_ff[0] <= CORDIC_GAIN;
      y_ff[0] <= '0;
      z_ff[0] <= ZW'($signed(r_in)) <<< (32 - ANGLE_BITS);
      q_ff[0] <= q_in;
   end

   for (genvar i = 0; i < N; i++) begin : g_rot
      localparam logic signed [ZW-1:0] AT = ZW'(atan_turns(i));
      always_ff @(posedge clock) begin
         if (!z_ff[i][ZW-1]) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - AT;
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + AT;
         end
         q_ff[i+1] <= q_ff[i];
      end
   end

   logic signed [CW-1:0] xr, yr;
   logic signed [VW-1:0] c_in, s_in, c_ff, s_ff;
   assign xr = (x_ff[N] + CW'(32)) >>> 6;
   assign yr = (y_ff[N] + CW'(32)) >>> 6;

   always_comb begin
      case (q_ff[N])
         2'd0:    begin c_in = xr[VW-1:0];     s_in = yr[VW-1:0];     end
         2'd1:    begin c_in = -yr[VW-1:0];    s_in = xr[VW-1:0];     end
         2'd2:    begin c_in = -xr[VW-1:0];    s_in = -yr[VW-1:0];    end
         default: begin c_in = yr[VW-1:0];     s_in = -xr[VW-1:0];    end
      endcase
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in;
      s_ff <= s_in;
   end
   assign cos_out = c_ff;
   assign sin_out = s_ff;

   logic unused;
   assign unused = reset;
endmodule

@@ design/dap_response.sv @@
// Basis vectors, response matrix and the F+/Fx contraction, all in registered stages.
module dap_response (
   input  logic                          clock,
   input  dap_pkg::arm_type              arm_x,
   input  dap_pkg::arm_type              arm_y,
   input  logic signed [dap_pkg::VW-1:0] cg, sg, cd, sd, cp, sp,
   output logic signed [15:0]            f_plus,
   output logic signed [15:0]            f_cross
);
   import dap_pkg::*;

   // stage A: first-level products
   logic signed [VW-1:0] cpsg_ff, cpcg_ff, spcg_ff, spsg_ff, spcd_ff, cpcd_ff;
   logic signed [VW-1:0] sd_a_ff;
   always_ff @(posedge clock) begin
      cpsg_ff <= rq24(64'(cp) * 64'(sg));
      cpcg_ff <= rq24(64'(cp) * 64'(cg));
      spcg_ff <= rq24(64'(sp) * 64'(cg));
      spsg_ff <= rq24(64'(sp) * 64'(sg));
      spcd_ff <= rq24(64'(sp) * 64'(cd));
      cpcd_ff <= rq24(64'(cp) * 64'(cd));
      sd_a_ff <= sd;
   end

   // stage B: products with sin(dec), then combine into m and n
   vec_type v1_ff, v2_ff;
   logic signed [VW-1:0] t1, t2, t3, t4;
   assign t1 = rq24(64'(spcg_ff) * 64'(sd_a_ff));
   assign t2 = rq24(64'(spsg_ff) * 64'(sd_a_ff));
   assign t3 = rq24(64'(cpcg_ff) * 64'(sd_a_ff));
   assign t4 = rq24(64'(cpsg_ff) * 64'(sd_a_ff));
   always_ff @(posedge clock) begin
      v1_ff[0] <= -cpsg_ff - t1;
      v1_ff[1] <= -cpcg_ff + t2;
      v1_ff[2] <= spcd_ff;
      v2_ff[0] <= spsg_ff - t3;
      v2_ff[1] <= spcg_ff + t4;
      v2_ff[2] <= cpcd_ff;
   end

   // response matrix from arm registers (user keeps static between items, unchecked)
   logic signed [DW-1:0] d_ff [3][3];
   for (genvar i = 0; i < 3; i++) begin : g_di
      for (genvar j = 0; j < 3; j++) begin : g_dj
         logic signed [33:0] pp;
         logic signed [33:0] pr;
         assign pp = 34'(arm_x[i] * arm_x[j]) - 34'(arm_y[i] * arm_y[j]);
         assign pr = (pp + 34'sd16) >>> 5;
         always_ff @(posedge clock) d_ff[i][j] <= pr[DW-1:0];
      end
   end

   // stage C: D*m and D*n
   vec_type dx_ff, dy_ff, v1_c_ff, v2_c_ff;
   for (genvar i = 0; i < 3; i++) begin : g_dv
      logic signed [63:0] sx, sy;
      assign sx = 64'(d_ff[i][0]) * 64'(v1_ff[0]) + 64'(d_ff[i][1]) * 64'(v1_ff[1])
                + 64'(d_ff[i][2]) * 64'(v1_ff[2]);
      assign sy = 64'(d_ff[i][0]) * 64'(v2_ff[0]) + 64'(d_ff[i][1]) * 64'(v2_ff[1])
                + 64'(d_ff[i][2]) * 64'(v2_ff[2]);
      always_ff @(posedge clock) begin
         dx_ff[i]   <= rq24(sx);
         dy_ff[i]   <= rq24(sy);
         v1_c_ff[i] <= v1_ff[i];
         v2_c_ff[i] <= v2_ff[i];
      end
   end

   // stage D: per-axis products; stage E: sum, round, saturate
   logic signed [63:0] pp_ff [3];
   logic signed [63:0] pc_ff [3];
   for (genvar i = 0; i < 3; i++) begin : g_fp
      always_ff @(posedge clock) begin
         pp_ff[i] <= 64'(v1_c_ff[i]) * 64'(dx_ff[i]) - 64'(v2_c_ff[i]) * 64'(dy_ff[i]);
         pc_ff[i] <= 64'(v1_c_ff[i]) * 64'(dy_ff[i]) + 64'(v2_c_ff[i]) * 64'(dx_ff[i]);
      end
   end

   function automatic logic signed [15:0] sat14(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = (v + (64'sd1 <<< 33)) >>> 34;
      if (r > 64'sd32767)       return 16'sh7FFF;
      else if (r < -64'sd32768) return 16'sh8000;
      else                      return r[15:0];
   endfunction

   logic signed [15:0] fp_ff, fc_ff;
   always_ff @(posedge clock) begin
      fp_ff <= sat14(pp_ff[0] + pp_ff[1] + pp_ff[2]);
      fc_ff <= sat14(pc_ff[0] + pc_ff[1] + pc_ff[2]);
   end
   assign f_plus  = fp_ff;
   assign f_cross = fc_ff;
endmodule

@@ design/detector_antenna_pattern_unit.sv @@
// Top level of the detector antenna pattern unit.
//   channel | ports                                   | direction
//   request | start, busy, req_*                      | in
//   result  | rsp_valid, rsp_f_plus/f_cross/hour_angle | out
//   config  | csr_write, csr_index, csr_data          | in
// One word per cycle; the result strobe follows the accepting edge through the CORDIC
// pipeline (input register, rotation stages, output register) and five response stages.
// busy is always low; the receiver cannot stall.
// Reset clears the arm registers and the valid pipeline.
module detector_antenna_pattern_unit #(
   parameter int ANGLE_BITS    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_sidereal_time,
   input  logic [15:0] req_right_ascension,
   input  logic [15:0] req_declination,
   input  logic [15:0] req_polarization,
   output logic        rsp_valid,
   output logic signed [15:0] rsp_f_plus,
   output logic signed [15:0] rsp_f_cross,
   output logic [15:0] rsp_hour_angle,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import dap_pkg::*;

   localparam int NC  = (CORDIC_STAGES < 1) ? 1 : ((CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES);
   localparam int LAT = NC + 2 + 5;

   arm_type arm_x_ff, arm_y_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            arm_x_ff[i] <= '0;
            arm_y_ff[i] <= '0;
         end
      end else if (csr_write) begin
         case (csr_index)
            REG_ARM_X_0: arm_x_ff[0] <= csr_data;
            REG_ARM_X_1: arm_x_ff[1] <= csr_data;
            REG_ARM_X_2: arm_x_ff[2] <= csr_data;
            REG_ARM_Y_0: arm_y_ff[0] <= csr_data;
            REG_ARM_Y_1: arm_y_ff[1] <= csr_data;
            REG_ARM_Y_2: arm_y_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic [ANGLE_BITS-1:0] ha;
   assign ha = ANGLE_BITS'(req_sidereal_time) - ANGLE_BITS'(req_right_ascension);

   logic signed [VW-1:0] cg, sg, cd, sd, cp, sp;
   dap_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cg (
      .clock, .reset, .angle(ha), .cos_out(cg), .sin_out(sg));
   dap_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cd (
      .clock, .reset, .angle(ANGLE_BITS'(req_declination)), .cos_out(cd), .sin_out(sd));
   dap_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cp (
      .clock, .reset, .angle(ANGLE_BITS'(req_polarization)), .cos_out(cp), .sin_out(sp));

   dap_response u_resp (
      .clock, .arm_x(arm_x_ff), .arm_y(arm_y_ff),
      .cg, .sg, .cd, .sd, .cp, .sp,
      .f_plus(rsp_f_plus), .f_cross(rsp_f_cross));

   logic              vld_ff [LAT];
   logic [15:0]       ha_ff  [LAT];
   always_ff @(posedge clock) begin
      if (reset) vld_ff[0] <= 1'b0;
      else       vld_ff[0] <= start & ~busy;
      ha_ff[0] <= 16'(ha);
      for (int i = 1; i < LAT; i++) begin
         if (reset) vld_ff[i] <= 1'b0;
         else       vld_ff[i] <= vld_ff[i-1];
         ha_ff[i] <= ha_ff[i-1];
      end
   end
   assign rsp_valid      = vld_ff[LAT-1];
   assign rsp_hour_angle = ha_ff[LAT-1];

   a_no_busy: assert property (@(posedge clock) !busy) else $error("busy raised");
   a_rst_quiet: assert property (@(posedge clock) reset |=> !vld_ff[0])
      else $error("valid after reset");
   a_arm_hold: assert property (@(posedge clock) disable iff (reset)
      !csr_write |=> $stable(arm_x_ff[0]) && $stable(arm_y_ff[0]))
      else $error("arm changed without write");
endmodule
